### rtl/core/ewse_pkg.sv
// Shared types, register indexes and constants of the encoder window speed estimator.
`timescale 1ns / 1ps

package ewse_pkg;

  // Default depth of the delta window.
  localparam int WINDOW_DEF = 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Reset values of the configuration registers.
  localparam logic [31:0] CENTER_RESET = 32'd32768;
  localparam logic [15:0] PERIOD_RESET = 16'd10;
  localparam logic [23:0] CPR_RESET    = 24'd1320;

  // Milliseconds per minute.
  localparam logic [15:0] RPM_SCALE = 16'd60000;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COUNTER_IS_WIDE   = 3'd0,
    REG_REVERSE_DIRECTION = 3'd1,
    REG_COUNTER_CENTER    = 3'd2,
    REG_SAMPLE_PERIOD_MS  = 3'd3,
    REG_COUNTS_PER_REV    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] counter_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] delta_count;
    logic signed [31:0] total_count;
    logic signed [31:0] speed_rpm;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL_PV,
    ST_MUL_DEN,
    ST_MUL_NUM,
    ST_ROUND,
    ST_START,
    ST_DIVIDE
  } ewse_state_t;

endpackage

### rtl/core/ewse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ewse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/ewse_divider.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module ewse_divider import ewse_pkg::*; #(
  parameter int N_W = 49,
  parameter int D_W = 47
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [D_W-1:0] rem_r, rem_nxt;
  logic [N_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic done_r, done_nxt;
  logic [D_W:0] trial;
  logic fits;

  // The quotient register starts out holding the dividend; each step shifts
  // one dividend bit into the partial remainder and one quotient bit in.
  // Done stays high with the quotient held until the next start, so a
  // consumer that is held up still sees the finished result.
  always_comb begin
    trial    = {rem_r, quo_r[N_W-1]};
    fits     = (trial >= {1'b0, den});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      cnt_nxt  = CNT_W'(N_W);
      done_nxt = 1'b0;
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? D_W'(trial - {1'b0, den}) : trial[D_W-1:0];
      quo_nxt  = {quo_r[N_W-2:0], fits};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/encoder_window_speed_estimator.sv
// Top level of the window-averaged quadrature encoder speed estimator.
`timescale 1ns / 1ps

// Each input beat is either a counter sample or a clear. A sample takes the
// difference of the reading from the configured rest value (16-bit wrapped
// and sign-extended, or full 32-bit), negates it when the direction is
// reversed, adds it to the 32-bit position total and pushes it into a window
// of the last WINDOW_SAMPLES deltas. The speed in rpm is the window sum times
// 60000 divided by sample period, samples held and counts per revolution,
// rounded to nearest with halves away from zero and saturated to 32 bits; a
// zero divisor gives zero. One beat is processed at a time: a sample spends
// most of its time in the divider, which retires one quotient bit per cycle;
// the three products share a single 32 x 24 multiplier in turn. A clear
// skips the multiplier and the divider. The result sits in an output
// register, so a new beat is taken while the previous result still waits;
// the block stalls only at the end of a sample or clear if that register
// has not yet been emptied. The window store is a small RAM that is never
// swept: a fill count decides whether the oldest entry is real, so a clear
// is immediate and there is no start-up pass.
// Configuration is written through a simple write port and should only be
// changed while the block is idle.

module encoder_window_speed_estimator import ewse_pkg::*; #(
  parameter int WINDOW_SAMPLES = WINDOW_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PTR_W   = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int VALID_W = $clog2(WINDOW_SAMPLES + 1);
  localparam int DEN_W   = 16 + VALID_W + 24;
  localparam int NUM_W   = ((DEN_W > 48) ? DEN_W : 48) + 1;

  // Sequencer and configuration.
  ewse_state_t state_r, state_nxt;
  logic        wide_r, wide_nxt;
  logic        reverse_r, reverse_nxt;
  logic [31:0] center_r, center_nxt;
  logic [15:0] period_r, period_nxt;
  logic [23:0] cpr_r, cpr_nxt;

  // Channel state.
  logic [VALID_W-1:0] valid_r, valid_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [31:0]        sum_r, sum_nxt;
  logic [31:0]        total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Working registers.
  logic [31:0]      delta_r, delta_nxt;
  logic             clr_r, clr_nxt;
  logic [55:0]      prod_r, prod_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  out_item_t        out_data_r, out_data_nxt;

  // Shared multiplier.
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] mul_p;

  // Combinational helpers.
  logic [31:0] diff;
  logic [31:0] delta_calc;
  logic [31:0] old_delta;
  logic [31:0] mag;
  logic        full;
  logic        sum_neg;
  logic        ovf_neg;
  logic        ovf_pos;
  logic [31:0] speed;

  // Window store and divider.
  logic             ram_we;
  logic [31:0]      ram_rdata;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  assign mul_p = mul_a * mul_b;

  ewse_ram #(
    .WIDTH (32),
    .DEPTH (WINDOW_SAMPLES),
    .ADDR_W(PTR_W)
  ) u_history (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ptr_r),
    .wr_data(delta_r),
    .rd_addr(ptr_r),
    .rd_data(ram_rdata)
  );

  ewse_divider #(
    .N_W(NUM_W),
    .D_W(DEN_W)
  ) u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num     (num_r),
    .den     (den_r),
    .done    (div_done),
    .quotient(div_quo)
  );

  // Counter difference, wrapped to the configured width and optionally
  // negated. Negating the most negative value wraps back onto itself.
  always_comb begin
    diff       = in_data.counter_value - center_r;
    delta_calc = wide_r ? diff : {{16{diff[15]}}, diff[15:0]};
    if (reverse_r) begin
      delta_calc = 32'd0 - delta_calc;
    end
  end

  // Once the window is full the entry about to be overwritten is the oldest
  // delta and leaves the running sum.
  assign full      = (valid_r == VALID_W'(WINDOW_SAMPLES));
  assign old_delta = full ? ram_rdata : 32'd0;

  // Magnitude of the window sum; the most negative sum gives 2^31 unsigned.
  assign sum_neg = sum_r[31];
  assign mag     = sum_neg ? (32'd0 - sum_r) : sum_r;

  // Rounded quotient, saturated to the signed 32-bit range.
  always_comb begin
    ovf_neg = (|div_quo[NUM_W-1:32]) || (div_quo[31] && (|div_quo[30:0]));
    ovf_pos = |div_quo[NUM_W-1:31];
    if (den_r == '0) begin
      speed = 32'd0;
    end else if (sum_neg) begin
      speed = ovf_neg ? 32'h8000_0000 : (32'd0 - div_quo[31:0]);
    end else begin
      speed = ovf_pos ? 32'h7FFF_FFFF : div_quo[31:0];
    end
  end

  // Next state, datapath and configuration writes.
  always_comb begin
    state_nxt     = state_r;
    wide_nxt      = wide_r;
    reverse_nxt   = reverse_r;
    center_nxt    = center_r;
    period_nxt    = period_r;
    cpr_nxt       = cpr_r;
    valid_nxt     = valid_r;
    ptr_nxt       = ptr_r;
    sum_nxt       = sum_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    delta_nxt     = delta_r;
    clr_nxt       = clr_r;
    prod_nxt      = prod_r;
    den_nxt       = den_r;
    num_nxt       = num_r;
    out_data_nxt  = out_data_r;
    mul_a         = 32'd0;
    mul_b         = 24'd0;
    ram_we        = 1'b0;
    div_start     = 1'b0;
    in_stall      = (state_r != ST_IDLE);

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COUNTER_IS_WIDE:   wide_nxt    = cfg_wdata[0];
        REG_REVERSE_DIRECTION: reverse_nxt = cfg_wdata[0];
        REG_COUNTER_CENTER:    center_nxt  = cfg_wdata[31:0];
        REG_SAMPLE_PERIOD_MS:  period_nxt  = cfg_wdata[15:0];
        REG_COUNTS_PER_REV:    cpr_nxt     = cfg_wdata[23:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.operation == OP_CLEAR) begin
            valid_nxt = '0;
            ptr_nxt   = '0;
            sum_nxt   = 32'd0;
            total_nxt = 32'd0;
            clr_nxt   = 1'b1;
            state_nxt = ST_DIVIDE;
          end else begin
            delta_nxt = delta_calc;
            clr_nxt   = 1'b0;
            state_nxt = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        ram_we    = 1'b1;
        total_nxt = total_r + delta_r;
        sum_nxt   = sum_r + delta_r - old_delta;
        if (!full) begin
          valid_nxt = valid_r + VALID_W'(1);
        end
        ptr_nxt   = (ptr_r == PTR_W'(WINDOW_SAMPLES - 1)) ? '0 : ptr_r + PTR_W'(1);
        state_nxt = ST_MUL_PV;
      end
      ST_MUL_PV: begin
        mul_a     = 32'(period_r);
        mul_b     = 24'(valid_r);
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_DEN;
      end
      ST_MUL_DEN: begin
        mul_a     = prod_r[31:0];
        mul_b     = cpr_r;
        den_nxt   = DEN_W'(mul_p);
        state_nxt = ST_MUL_NUM;
      end
      ST_MUL_NUM: begin
        mul_a     = mag;
        mul_b     = 24'(RPM_SCALE);
        prod_nxt  = mul_p;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        // Adding half the divisor makes the truncating divide round to
        // nearest, halves away from zero on the magnitude.
        num_nxt   = NUM_W'(prod_r[47:0]) + NUM_W'(den_r >> 1);
        state_nxt = ST_START;
      end
      ST_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        // A clear skips the divider and lands here straight from idle.
        if ((clr_r || div_done) && (!out_valid_r || !out_stall)) begin
          if (clr_r) begin
            out_data_nxt = '0;
          end else begin
            out_data_nxt.delta_count = delta_r;
            out_data_nxt.total_count = total_r;
            out_data_nxt.speed_rpm   = speed;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wide_r      <= 1'b0;
      reverse_r   <= 1'b0;
      center_r    <= CENTER_RESET;
      period_r    <= PERIOD_RESET;
      cpr_r       <= CPR_RESET;
      valid_r     <= '0;
      ptr_r       <= '0;
      sum_r       <= 32'd0;
      total_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wide_r      <= wide_nxt;
      reverse_r   <= reverse_nxt;
      center_r    <= center_nxt;
      period_r    <= period_nxt;
      cpr_r       <= cpr_nxt;
      valid_r     <= valid_nxt;
      ptr_r       <= ptr_nxt;
      sum_r       <= sum_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delta_r    <= delta_nxt;
    clr_r      <= clr_nxt;
    prod_r     <= prod_nxt;
    den_r      <= den_nxt;
    num_r      <= num_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/ewse_checker.sv
// Port-level assertions for the encoder window speed estimator, bound to the top level.
`timescale 1ns / 1ps

module ewse_checker import ewse_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A held result beat keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Only one beat is worked on at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken while busy");

  // Reset leaves no result pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

  // A clear with an empty output register yields an all-zero result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.operation == OP_CLEAR) && !out_valid)
      |=> ##1 (!$past(rst_n) || (out_valid && (out_data == '0))))
    else $error("clear did not give a zero result");

endmodule

bind encoder_window_speed_estimator ewse_checker u_ewse_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

### bench/tb_encoder_window_speed_estimator.sv
// Self-checking testbench for the encoder window speed estimator top level.
`timescale 1ns / 1ps

// The bench drives sample and clear beats into the estimator and checks every
// result beat against a predictor kept inside the bench. The predictor holds
// its own copy of the registers, the delta window and the position total, and
// is advanced at the rising edge at which a beat is accepted. Its results go
// into a queue, and each result beat that leaves the block is compared field
// by field with the oldest entry of that queue.
//
// The run has two parts. A short directed script comes first: the reset
// state, the edges of the 16-bit wrap, a clear, the most negative delta with
// and without reversal, saturation of the speed, both zero divisors, the
// largest divisor, writes to indexes past the register list, and enough
// samples to wrap the window. Then come random phases: each one waits until
// the block is idle, retunes every register and sends a run of beats, mostly
// samples near the rest value with a few clears, wide jumps and raw values.
//
// Inputs change on the falling edge and everything is sampled on the rising
// edge, so nothing depends on the order of events within a time step. The
// sender works in bursts with random gaps, and the receiver stalls according
// to a mode that is picked again at random whenever its run ends.

module tb_encoder_window_speed_estimator;
  import ewse_pkg::*;

  localparam int CLOCK_HALF      = 5;
  localparam int RESET_CYCLES    = 12;
  localparam int RANDOM_PHASES   = 8;
  localparam int BEATS_PER_PHASE = 50;
  // Long enough for the block to finish a sample.
  localparam int SETTLE_CYCLES   = 120;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int SHOWN_LIMIT     = 10;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_FIRST = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LAST  = 3'd7;

  // How the receiving side treats the result channel at the moment.
  typedef enum int {
    SINK_FREE,
    SINK_PATCHY,
    SINK_CHOKED
  } sink_mode_t;

  // One line of the directed script: either a register write or a beat. A
  // beat may carry a result typed in by hand, which then replaces the
  // prediction as the thing to check against.
  typedef struct packed {
    logic                   is_write;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
    in_item_t               beat;
    logic                   pinned;
    out_item_t              pinned_result;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // Hand-typed result that goes with the beat now on the input channel.
  logic      pin_now;
  out_item_t pin_value;

  // Predictor copy of the registers.
  logic        set_wide;
  logic        set_reverse;
  logic [31:0] set_centre;
  logic [15:0] set_period;
  logic [23:0] set_cpr;

  // Predictor copy of the channel state.
  logic [31:0] window_store [WINDOW_DEF];
  int unsigned store_slot;
  int unsigned samples_held;
  logic [31:0] window_total;
  logic [31:0] position_sum;

  out_item_t   awaited_results [$];
  script_row_t directed_script [$];

  int         fault_count = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  sink_mode_t sink_mode = SINK_FREE;
  int         mode_left = 0;

  always begin
    #CLOCK_HALF clk = 1'b1;
    #CLOCK_HALF clk = 1'b0;
  end

  encoder_window_speed_estimator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Empties the window, the position total and the fill count, as reset and a
  // clear beat both do.
  function automatic void clear_window_model();
    for (int k = 0; k < WINDOW_DEF; k++) begin
      window_store[k] = '0;
    end
    store_slot   = 0;
    samples_held = 0;
    window_total = '0;
    position_sum = '0;
  endfunction

  // Advances the predicted channel state by one accepted beat and returns the
  // result beat that the block should produce for it.
  function automatic out_item_t model_encoder_beat(input in_item_t beat);
    logic [31:0] delta;
    logic [31:0] oldest;
    logic [31:0] magnitude;
    logic [15:0] short_diff;
    logic [63:0] divisor;
    logic [63:0] scaled;
    logic [63:0] quotient;
    out_item_t   result;
    if (beat.operation == OP_CLEAR) begin
      clear_window_model();
      return '0;
    end
    // In the narrow mode only the low 16 bits of the difference count, and
    // they are sign-extended so that a counter wrap reads as a small step.
    if (set_wide) begin
      delta = beat.counter_value - set_centre;
    end else begin
      short_diff = beat.counter_value[15:0] - set_centre[15:0];
      delta = {{16{short_diff[15]}}, short_diff};
    end
    if (set_reverse) begin
      delta = 32'd0 - delta;
    end
    position_sum = position_sum + delta;
    // Until the window is full nothing drops out of it and the divisor uses
    // the number of samples held so far.
    oldest = '0;
    if (samples_held >= WINDOW_DEF) begin
      oldest = window_store[store_slot];
    end else begin
      samples_held++;
    end
    window_store[store_slot] = delta;
    window_total = window_total + delta - oldest;
    store_slot = (store_slot + 1) % WINDOW_DEF;
    divisor = 64'(set_period) * 64'(samples_held) * 64'(set_cpr);
    result.delta_count = delta;
    result.total_count = position_sum;
    if (divisor == 64'd0) begin
      result.speed_rpm = '0;
    end else begin
      // Round the magnitude half up, which is half away from zero once the
      // sign goes back on, then clamp to the signed 32-bit range.
      magnitude = window_total[31] ? 32'd0 - window_total : window_total;
      scaled = 64'(magnitude) * 64'(RPM_SCALE);
      quotient = (scaled + divisor / 64'd2) / divisor;
      if (window_total[31]) begin
        if (quotient > 64'h8000_0000) begin
          quotient = 64'h8000_0000;
        end
        result.speed_rpm = 32'd0 - quotient[31:0];
      end else begin
        if (quotient > 64'h7FFF_FFFF) begin
          quotient = 64'h7FFF_FFFF;
        end
        result.speed_rpm = quotient[31:0];
      end
    end
    return result;
  endfunction

  // Counts a failure and shows the first few of them in full.
  task automatic note_fault(input string what, input out_item_t want, input out_item_t got);
    fault_count++;
    if (fault_count <= SHOWN_LIMIT) begin
      $display("%s at %0t ns: delta %0d (want %0d), total %0d (want %0d), rpm %0d (want %0d)",
               what, $time, got.delta_count, want.delta_count, got.total_count,
               want.total_count, got.speed_rpm, want.speed_rpm);
    end
  endtask

  // Both channels are watched at the rising edge. An accepted input beat
  // advances the predictor at once, so its state always matches the order in
  // which the block took the beats.
  always @(posedge clk) begin : result_check
    out_item_t predicted;
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted = model_encoder_beat(in_data);
        awaited_results.push_back(pin_now ? pin_value : predicted);
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          note_fault("result beat with nothing awaited", '0, out_data);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.delta_count !== want.delta_count ||
              out_data.total_count !== want.total_count ||
              out_data.speed_rpm !== want.speed_rpm) begin
            note_fault("result mismatch", want, out_data);
          end
        end
      end
    end
  end

  // The receiver switches between taking every beat, stalling at random, and
  // stalling most of the time, so the output register is often still full
  // when the block finishes its next sample.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    case (sink_mode)
      SINK_FREE:   out_stall = 1'b0;
      SINK_PATCHY: out_stall = 1'($urandom_range(0, 1));
      default:     out_stall = ($urandom_range(0, 7) != 0);
    endcase
  end

  // Ends a run that hangs.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Puts one beat on the input channel and returns at the falling edge after
  // it was taken. Between bursts valid drops for a random gap; within a burst
  // it stays high and only the payload changes.
  task automatic send_beat(input in_item_t beat, input logic pin, input out_item_t pin_result);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_data   = beat;
    pin_now   = pin;
    pin_value = pin_result;
    in_valid  = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Holds the input back until every awaited result has left the block.
  task automatic drain_results();
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  // Writes one register and mirrors it in the predictor. Only called while
  // the block is idle.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (index)
      REG_COUNTER_IS_WIDE:   set_wide    = value[0];
      REG_REVERSE_DIRECTION: set_reverse = value[0];
      REG_COUNTER_CENTER:    set_centre  = value;
      REG_SAMPLE_PERIOD_MS:  set_period  = value[15:0];
      REG_COUNTS_PER_REV:    set_cpr     = value[23:0];
      default: ;
    endcase
  endtask

  task automatic add_write(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] value);
    script_row_t row;
    row = '0;
    row.is_write  = 1'b1;
    row.reg_index = index;
    row.reg_value = value;
    directed_script.push_back(row);
  endtask

  task automatic add_beat(input op_t op, input logic [31:0] reading);
    script_row_t row;
    row = '0;
    row.beat.operation     = op;
    row.beat.counter_value = reading;
    directed_script.push_back(row);
  endtask

  task automatic add_pinned(input op_t op, input logic [31:0] reading, input logic [31:0] delta,
                            input logic [31:0] total, input logic [31:0] rpm);
    script_row_t row;
    row = '0;
    row.beat.operation               = op;
    row.beat.counter_value           = reading;
    row.pinned                       = 1'b1;
    row.pinned_result.delta_count    = delta;
    row.pinned_result.total_count    = total;
    row.pinned_result.speed_rpm      = rpm;
    directed_script.push_back(row);
  endtask

  // Picks a counter reading: mostly a small step either side of the rest
  // value, sometimes a jump past the 16-bit wrap, a raw value or an extreme.
  function automatic logic [31:0] pick_reading();
    int offset;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        offset = int'($urandom_range(0, 4000)) - 2000;
        return set_centre + 32'(offset);
      end
      6: begin
        offset = int'($urandom_range(0, 80000)) - 40000;
        return set_centre + 32'(offset);
      end
      7: return $urandom;
      8: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return set_centre;
    endcase
  endfunction

  // Writes every register for a new phase. The first phase keeps to the
  // values of a real drive so that the speeds stay mostly in range; later
  // phases mix in the extremes. Unused data bits are filled at random since
  // the block must ignore them.
  task automatic retune_registers(input logic lifelike);
    logic [31:0] centre;
    logic [31:0] period;
    logic [31:0] cpr;
    centre = 32'd32768;
    period = 32'd10;
    cpr    = 32'd1320;
    if (!lifelike) begin
      case ($urandom_range(0, 5))
        0:       centre = 32'd0;
        1:       centre = 32'hFFFF_FFFF;
        2:       centre = $urandom;
        default: centre = 32'd32768;
      endcase
      case ($urandom_range(0, 7))
        0:       period = 32'd0;
        1:       period = 32'd1;
        2:       period = 32'd65535;
        3:       period = $urandom_range(1, 65535);
        default: period = $urandom_range(1, 50);
      endcase
      case ($urandom_range(0, 7))
        0:       cpr = 32'd0;
        1:       cpr = 32'd1;
        2:       cpr = 32'h00FF_FFFF;
        3:       cpr = $urandom_range(1, 32'h00FF_FFFF);
        default: cpr = $urandom_range(100, 5000);
      endcase
    end
    write_register(REG_COUNTER_IS_WIDE, $urandom);
    write_register(REG_REVERSE_DIRECTION, $urandom);
    write_register(REG_COUNTER_CENTER, centre);
    write_register(REG_SAMPLE_PERIOD_MS, {16'($urandom_range(0, 65535)), period[15:0]});
    write_register(REG_COUNTS_PER_REV, {8'($urandom), cpr[23:0]});
    if ($urandom_range(0, 2) == 0) begin
      write_register(3'($urandom_range(SPARE_INDEX_FIRST, SPARE_INDEX_LAST)), $urandom);
    end
  endtask

  initial begin : stimulus
    in_item_t    beat;
    script_row_t row;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    out_stall = 1'b0;
    pin_now   = 1'b0;
    pin_value = '0;

    set_wide    = 1'b0;
    set_reverse = 1'b0;
    set_centre  = CENTER_RESET;
    set_period  = PERIOD_RESET;
    set_cpr     = CPR_RESET;
    clear_window_model();

    // Reset settings: a reading at the rest value moves nothing, then the
    // two ends of the 16-bit wrap and a clear that must zero everything.
    add_pinned(OP_SAMPLE, 32'd32768, 32'd0, 32'd0, 32'd0);
    add_beat(OP_SAMPLE, 32'd34088);
    add_beat(OP_SAMPLE, 32'h0000_0000);
    add_beat(OP_SAMPLE, 32'hFFFF_FFFF);
    add_beat(OP_SAMPLE, 32'h0000_7FFF);
    add_pinned(OP_CLEAR, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    // Full-width difference with the smallest divisor: the most negative
    // delta drives the speed into negative saturation.
    add_write(REG_COUNTER_IS_WIDE, 32'd1);
    add_write(REG_COUNTER_CENTER, 32'd0);
    add_write(REG_SAMPLE_PERIOD_MS, 32'd1);
    add_write(REG_COUNTS_PER_REV, 32'd1);
    add_write(SPARE_INDEX_FIRST, 32'hFFFF_FFFF);
    add_write(SPARE_INDEX_LAST, 32'hFFFF_FFFF);
    add_pinned(OP_SAMPLE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // Reversed: negating the most negative delta leaves it alone, and the
    // position total and window sum wrap.
    add_write(REG_REVERSE_DIRECTION, 32'd1);
    add_beat(OP_SAMPLE, 32'h8000_0000);
    add_beat(OP_SAMPLE, 32'h7FFF_FFFF);
    add_beat(OP_SAMPLE, 32'h0000_0001);
    // Each factor of the divisor at zero, then the largest divisor.
    add_write(REG_SAMPLE_PERIOD_MS, 32'd0);
    add_beat(OP_SAMPLE, 32'h0001_2345);
    add_write(REG_SAMPLE_PERIOD_MS, 32'd65535);
    add_write(REG_COUNTS_PER_REV, 32'd0);
    add_beat(OP_SAMPLE, 32'hDEAD_BEEF);
    add_write(REG_COUNTS_PER_REV, 32'h00FF_FFFF);
    add_beat(OP_SAMPLE, 32'h7FFF_FFFF);
    // Back to the narrow difference with an awkward rest value; a dozen
    // samples fill the window and push the oldest entries out of it.
    add_write(REG_COUNTER_IS_WIDE, 32'd0);
    add_write(REG_REVERSE_DIRECTION, 32'd0);
    add_write(REG_COUNTER_CENTER, 32'hFFFF_FFFF);
    add_write(REG_SAMPLE_PERIOD_MS, 32'd10);
    add_write(REG_COUNTS_PER_REV, 32'd1320);
    for (int k = 0; k < 12; k++) begin
      add_beat(OP_SAMPLE, 32'hFFFF_FFF0 + 32'(k * 4099));
    end
    add_pinned(OP_CLEAR, 32'h0000_0000, 32'd0, 32'd0, 32'd0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    for (int k = 0; k < directed_script.size(); k++) begin
      row = directed_script[k];
      if (row.is_write) begin
        drain_results();
        write_register(row.reg_index, row.reg_value);
      end else begin
        send_beat(row.beat, row.pinned, row.pinned_result);
      end
    end

    // Random phases. Each one starts from an idle block, which also gives
    // the pause in which every awaited result comes out before more input.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      retune_registers(phase == 0);
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        beat.operation     = ($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_SAMPLE;
        beat.counter_value = pick_reading();
        send_beat(beat, 1'b0, '0);
      end
    end

    // Let the last results out, then wait a little longer so that a stray
    // extra result beat would still be caught.
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (awaited_results.size() != 0) begin
      fault_count += awaited_results.size();
      $display("%0d result beats never arrived", awaited_results.size());
    end

    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
